// File: hw/rtl/morus_pkg.sv
// Shared types and word functions for the MORUS-640 keystream unit.
// No dependencies; imported by every RTL file of this block.
package morus_pkg;

   localparam int WordWidth  = 128;
   localparam int LaneWidth  = 32;
   localparam int NumWords   = 5;
   localparam int CountWidth = 8;

   // Register map: index from byte address bits above the word offset
   localparam int CsrAddrWidth = 3;
   localparam logic [0:0] RegStepCount = 1'b0;
   localparam logic [CountWidth-1:0] StepCountReset = 8'd16;

   // Lane rotation amounts of the five rounds
   localparam int Rot0 = 5;
   localparam int Rot1 = 31;
   localparam int Rot2 = 7;
   localparam int Rot3 = 22;
   localparam int Rot4 = 13;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [NumWords-1:0] state_type;

   // Rotate each 32-bit lane left by n
   function automatic word_type lane_rotl(input word_type w, input int n);
      word_type r;
      logic [LaneWidth-1:0] x;
      for (int k = 0; k < 4; k++) begin
         x = w[k*LaneWidth +: LaneWidth];
         r[k*LaneWidth +: LaneWidth] = (x << n) | (x >> (LaneWidth - n));
      end
      return r;
   endfunction

   // Lanes (l0,l1,l2,l3) -> (l1,l2,l3,l0); lane 0 sits in the top bits
   function automatic word_type word_rot32(input word_type w);
      return {w[95:0], w[127:96]};
   endfunction

   // Lanes -> (l2,l3,l0,l1)
   function automatic word_type word_rot64(input word_type w);
      return {w[63:0], w[127:64]};
   endfunction

   // Lanes -> (l3,l0,l1,l2)
   function automatic word_type word_rot96(input word_type w);
      return {w[31:0], w[127:32]};
   endfunction

endpackage

// File: hw/rtl/morus_csr.sv
// APB-style register file holding the step count.
// Depends on morus_pkg for the register map and widths.
module morus_csr
   import morus_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output logic [CountWidth-1:0]   step_count
);

   logic [CountWidth-1:0] step_count_ff;
   logic [CountWidth-1:0] step_count_in;
   logic                  wr_en;
   logic [0:0]            reg_index;

   assign reg_index  = csr_paddr[CsrAddrWidth-1 -: 1];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Take the low byte on a write to the step count register
   always_comb begin
      step_count_in = step_count_ff;
      if (wr_en && reg_index == RegStepCount) begin
         step_count_in = csr_pwdata[CountWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= StepCountReset;
      end else begin
         step_count_ff <= step_count_in;
      end
   end

   // Read back; unmapped addresses return zero
   always_comb begin
      csr_prdata = '0;
      if (reg_index == RegStepCount) begin
         csr_prdata = {{(32-CountWidth){1'b0}}, step_count_ff};
      end
   end

   assign step_count = step_count_ff;

endmodule

// File: hw/rtl/morus_round_unit.sv
// Shared state update unit: one full five-round step, plus the half step
// and keystream extraction. Depends on morus_pkg for word functions.
module morus_round_unit
   import morus_pkg::*;
(
   input  state_type state,
   output state_type next_state,
   output word_type  keystream
);

   word_type t0, t1, t2, t3, t4;
   word_type r0, r1, r2;
   word_type n0, n1;
   word_type s3r, s4r;
   word_type h0, h1, h3;

   assign s3r = word_rot32(state[3]);
   assign s4r = word_rot64(state[4]);

   // Five rounds, each feeding the partially updated words to the next
   always_comb begin
      t0 = state[3] ^ state[0] ^ (state[1] & state[2]);
      r0 = lane_rotl(t0, Rot0);
      n0 = word_rot96(r0);

      t1 = state[4] ^ state[1] ^ (state[2] & s3r);
      r1 = lane_rotl(t1, Rot1);
      n1 = word_rot64(r1);

      t2 = state[2] ^ (s3r & s4r) ^ r0;
      r2 = lane_rotl(t2, Rot2);

      t3 = s3r ^ (s4r & n0) ^ r1;
      t4 = s4r ^ (n0 & n1) ^ r2;

      next_state[0] = n0;
      next_state[1] = n1;
      next_state[2] = word_rot32(r2);
      next_state[3] = lane_rotl(t3, Rot3);
      next_state[4] = lane_rotl(t4, Rot4);
   end

   // Half step folded straight into the keystream
   always_comb begin
      h0 = lane_rotl(state[0] ^ (state[1] & state[2]) ^ state[3], Rot0);
      h1 = lane_rotl(state[1] ^ (state[2] & s3r) ^ state[4], Rot1);
      h3 = s3r;
      keystream = (state[2] & h3) ^ word_rot96(h1) ^ h0;
   end

endmodule

// File: hw/rtl/morus_state_update_keystream_unit.sv
// Top level of the MORUS-640 keystream unit: sequencer, state register,
// output register. Depends on morus_pkg, morus_csr and morus_round_unit.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_s0_hi .. req_s4_lo
//   rsp     | out       | rsp_valid/rsp_stall | rsp_keystream_hi/lo
//   csr     | in/out    | APB psel/penable    | step_count at byte 0
//
// An item is loaded, makes step_count full steps through the shared round
// unit, then takes the half step and keystream into the output register.
// The next item is taken only after that; the step count resets to 16.
// Reset is synchronous; it clears the sequencer and the result valid.
// A new item is taken while a result still waits; the finishing cycle
// holds until the output register is free.
module morus_state_update_keystream_unit
   import morus_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [63:0]             req_s0_hi,
   input  logic [63:0]             req_s0_lo,
   input  logic [63:0]             req_s1_hi,
   input  logic [63:0]             req_s1_lo,
   input  logic [63:0]             req_s2_hi,
   input  logic [63:0]             req_s2_lo,
   input  logic [63:0]             req_s3_hi,
   input  logic [63:0]             req_s3_lo,
   input  logic [63:0]             req_s4_hi,
   input  logic [63:0]             req_s4_lo,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [63:0]             rsp_keystream_hi,
   output logic [63:0]             rsp_keystream_lo,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam logic StIdle = 1'b0;
   localparam logic StRun  = 1'b1;

   logic                  st_ff, st_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              ks_ff, ks_in;
   logic [CountWidth-1:0] step_count;
   state_type             next_state;
   word_type              keystream;
   logic                  req_xfer;
   logic                  out_free;

   morus_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .step_count  (step_count)
   );

   morus_round_unit u_round (
      .state      (state_ff),
      .next_state (next_state),
      .keystream  (keystream)
   );

   assign req_stall = (st_ff != StIdle);
   assign req_xfer  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Sequencer: load, step while the count runs, then emit
   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      state_in     = state_ff;
      ks_in        = ks_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (st_ff)
         StIdle: begin
            if (req_xfer) begin
               state_in[0] = {req_s0_hi, req_s0_lo};
               state_in[1] = {req_s1_hi, req_s1_lo};
               state_in[2] = {req_s2_hi, req_s2_lo};
               state_in[3] = {req_s3_hi, req_s3_lo};
               state_in[4] = {req_s4_hi, req_s4_lo};
               cnt_in      = step_count;
               st_in       = StRun;
            end
         end
         StRun: begin
            if (cnt_ff != '0) begin
               // advance one full step
               state_in = next_state;
               cnt_in   = cnt_ff - 1'b1;
            end else if (out_free) begin
               // half step and transfer into the output register
               ks_in        = keystream;
               rsp_valid_in = 1'b1;
               st_in        = StIdle;
            end
         end
         default: begin
            st_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= StIdle;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      state_ff <= state_in;
      ks_ff    <= ks_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_keystream_hi = ks_ff[127:64];
   assign rsp_keystream_lo = ks_ff[63:0];

endmodule

// File: verif/morus_state_update_keystream_unit_tb.sv
// Self-checking testbench for the MORUS-640 keystream unit: drives states,
// predicts each keystream word and checks results in order.
// Depends on morus_pkg and morus_state_update_keystream_unit.
module morus_state_update_keystream_unit_tb
   import morus_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrAddrWidth-1:0] StepCountAddr = {RegStepCount, 2'b00};
   localparam logic [CsrAddrWidth-1:0] UnusedRegAddr = 3'd4;
   localparam int MaxIdle = 8;
   localparam int MaxPrintedErrors = 50;

   typedef enum int unsigned {
      PatZero, PatOnes, PatAlt, PatAltInv, PatWalk, PatCorner
   } pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_s0_hi = '0, req_s0_lo = '0, req_s1_hi = '0, req_s1_lo = '0;
   logic [63:0] req_s2_hi = '0, req_s2_lo = '0, req_s3_hi = '0, req_s3_lo = '0;
   logic [63:0] req_s4_hi = '0, req_s4_lo = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_keystream_hi, rsp_keystream_lo;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state and pending keystream words
   logic [CountWidth-1:0] model_step_count = StepCountReset;
   word_type    keystream_expected[$];
   int unsigned mismatch_count = 0;
   logic        tx_idle = 1'b1;
   logic        rx_idle = 1'b1;
   int unsigned rx_hold_cycles = 0;

   morus_state_update_keystream_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_s0_hi        (req_s0_hi),
      .req_s0_lo        (req_s0_lo),
      .req_s1_hi        (req_s1_hi),
      .req_s1_lo        (req_s1_lo),
      .req_s2_hi        (req_s2_hi),
      .req_s2_lo        (req_s2_lo),
      .req_s3_hi        (req_s3_hi),
      .req_s3_lo        (req_s3_lo),
      .req_s4_hi        (req_s4_hi),
      .req_s4_lo        (req_s4_lo),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_keystream_hi (rsp_keystream_hi),
      .rsp_keystream_lo (rsp_keystream_lo),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // Rotate every 32-bit lane left by n (1..31)
   function automatic word_type rotl_each_lane(input word_type w, input int n);
      word_type r;
      logic [63:0] twice;
      for (int k = 0; k < 4; k++) begin
         twice = {w[32*k +: 32], w[32*k +: 32]} >> (32 - n);
         r[32*k +: 32] = twice[31:0];
      end
      return r;
   endfunction

   // Rotate the whole word left by a number of lanes (1..3)
   function automatic word_type rotl_word_by_lanes(input word_type w, input int lanes);
      logic [255:0] twice;
      twice = {w, w} >> (128 - 32 * lanes);
      return twice[127:0];
   endfunction

   // Apply the configured full steps, the half step, then form the keystream
   function automatic word_type predict_keystream(input state_type st);
      word_type s0, s1, s2, s3, s4, t0, t1, t2;
      s0 = st[0];
      s1 = st[1];
      s2 = st[2];
      s3 = st[3];
      s4 = st[4];
      for (int i = 0; i < int'(model_step_count); i++) begin
         t0 = rotl_each_lane(s3 ^ s0 ^ (s1 & s2), Rot0);
         s0 = rotl_word_by_lanes(t0, 3);
         t1 = rotl_each_lane(s4 ^ s1 ^ (s2 & rotl_word_by_lanes(s3, 1)), Rot1);
         s1 = rotl_word_by_lanes(t1, 2);
         t2 = rotl_each_lane(s2 ^ (rotl_word_by_lanes(s3, 1) & rotl_word_by_lanes(s4, 2))
                             ^ t0, Rot2);
         s2 = rotl_word_by_lanes(t2, 1);
         s3 = rotl_each_lane(rotl_word_by_lanes(s3, 1) ^ (rotl_word_by_lanes(s4, 2) & s0)
                             ^ t1, Rot3);
         s4 = rotl_each_lane(rotl_word_by_lanes(s4, 2) ^ (s0 & s1) ^ t2, Rot4);
      end
      // half step: words 0 and 1 from the old words, then rotate word 3
      t0 = rotl_each_lane((s1 & s2) ^ s0 ^ s3, Rot0);
      t1 = rotl_each_lane((s2 & rotl_word_by_lanes(s3, 1)) ^ s1 ^ s4, Rot1);
      s3 = rotl_word_by_lanes(s3, 1);
      return (s2 & s3) ^ rotl_word_by_lanes(t1, 3) ^ t0;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic state_type directed_state(input pattern_type pattern);
      state_type st;
      for (int k = 0; k < NumWords; k++) begin
         case (pattern)
            PatZero:   st[k] = '0;
            PatOnes:   st[k] = '1;
            PatAlt:    st[k] = {4{32'hAAAA_AAAA}};
            PatAltInv: st[k] = {4{32'h5555_5555}};
            PatWalk:   st[k] = word_type'(1) << (k * 29 + 3);
            default:   st[k] = {1'b1, {(WordWidth-2){1'b0}}, 1'b1};
         endcase
      end
      return st;
   endfunction

   // Mostly dense random words, with some sparse and some all-0/all-1 words
   function automatic state_type random_state();
      state_type st;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < NumWords; k++) begin
         st[k] = {rand64(), rand64()};
         if (kind == 0)
            st[k] = st[k] & {rand64(), rand64()} & {rand64(), rand64()};
         else if (kind == 1)
            st[k] = $urandom_range(0, 1) ? '1 : '0;
      end
      return st;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MaxPrintedErrors)
         $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
   endtask

   // One APB transfer: setup phase, access phase until pready, then idle
   task automatic csr_transfer(input logic write, input logic [CsrAddrWidth-1:0] addr,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_step_count();
      logic [31:0] rdata;
      csr_transfer(1'b0, StepCountAddr, '0, rdata);
      if (rdata[CountWidth-1:0] !== model_step_count)
         report_mismatch("step_count readback", 64'(rdata), 64'(model_step_count));
   endtask

   task automatic set_step_count(input logic [31:0] value);
      logic [31:0] ignored;
      csr_transfer(1'b1, StepCountAddr, value, ignored);
      model_step_count = value[CountWidth-1:0];
      check_step_count();
   endtask

   // Offer one state after a random gap (when tx_idle is set) and hold it until the transfer
   task automatic send_state(input state_type st);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(0, MaxIdle) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_s0_hi <= st[0][127:64];
      req_s0_lo <= st[0][63:0];
      req_s1_hi <= st[1][127:64];
      req_s1_lo <= st[1][63:0];
      req_s2_hi <= st[2][127:64];
      req_s2_lo <= st[2][63:0];
      req_s3_hi <= st[3][127:64];
      req_s3_lo <= st[3][63:0];
      req_s4_hi <= st[4][127:64];
      req_s4_lo <= st[4][63:0];
      do @(posedge clock); while (req_stall);
      keystream_expected.push_back(predict_keystream(st));
   endtask

   // Stop offering and wait until every pending keystream word has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      while (keystream_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_reset_count();
      check_step_count();
      send_state(directed_state(PatZero));
      send_state(directed_state(PatOnes));
      send_state(directed_state(PatWalk));
      send_state(random_state());
      drain_results();
   endtask

   task automatic test_zero_steps();
      set_step_count(32'd0);
      for (int p = PatZero; p <= PatCorner; p++)
         send_state(directed_state(pattern_type'(p)));
      drain_results();
   endtask

   task automatic test_max_steps();
      set_step_count(32'd255);
      send_state(directed_state(PatOnes));
      send_state(random_state());
      drain_results();
   endtask

   // Upper data bits of a write are dropped
   task automatic test_wide_write();
      set_step_count(32'hABCD_EF03);
      send_state(directed_state(PatAlt));
      send_state(random_state());
      drain_results();
   endtask

   // A write to an unmapped address leaves step_count alone
   task automatic test_unknown_register();
      logic [31:0] ignored;
      csr_transfer(1'b1, UnusedRegAddr, 32'h0000_00FF, ignored);
      check_step_count();
      send_state(directed_state(PatAltInv));
      send_state(random_state());
      drain_results();
   endtask

   // Hold the result side for a long stretch while states keep coming
   task automatic test_backpressure();
      set_step_count(32'd2);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      rx_hold_cycles = 400;
      for (int i = 0; i < 12; i++)
         send_state(random_state());
      drain_results();
   endtask

   task automatic test_random_traffic();
      int unsigned steps;
      int unsigned count;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       steps = 0;
            3:       steps = 255;
            6:       steps = 1;
            9:       steps = 16;
            default: steps = $urandom_range(2, 24);
         endcase
         count = (steps == 255) ? 8 : 220;
         tx_idle = phase[0];
         rx_idle = phase[1];
         set_step_count(($urandom & 32'hFFFF_FF00) | steps);
         for (int i = 0; i < int'(count); i++) begin
            // pause the sender once until everything has come back
            if (phase == 5 && i == int'(count / 2))
               drain_results();
            send_state(random_state());
         end
         drain_results();
      end
   endtask

   // Result side: random stall before each transfer when rx_idle is set, or one long hold
   initial begin : receive_keystream
      int unsigned wait_cycles;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = rx_idle ? $urandom_range(0, MaxIdle) : 0;
         if (rx_hold_cycles > 0) begin
            wait_cycles = rx_hold_cycles;
            rx_hold_cycles = 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each transfer with the oldest pending keystream word
   always @(posedge clock) begin : check_keystream
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (keystream_expected.size() == 0) begin
            report_mismatch("keystream with none pending", rsp_keystream_hi, '0);
         end else begin
            want = keystream_expected.pop_front();
            if (rsp_keystream_hi !== want[127:64])
               report_mismatch("keystream_hi", rsp_keystream_hi, want[127:64]);
            if (rsp_keystream_lo !== want[63:0])
               report_mismatch("keystream_lo", rsp_keystream_lo, want[63:0]);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_count();
      test_zero_steps();
      test_max_steps();
      test_wide_write();
      test_unknown_register();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (int'(model_step_count) + 8) @(posedge clock);
      if (mismatch_count == 0 && keystream_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
